[design/wmic_pkg.sv]
// Package for the weighted majority interval counter.
// Holds the sizing constants and the record that travels along the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package wmic_pkg;

	// Most items stored between two start requests. Entry zero of the store
	// (the empty prefix) is implicit, so the chain has MAX_LEN cells.
	localparam int MAX_LEN = 1024;

	// Wide enough for a stored count of up to MAX_LEN + 1.
	localparam int CNT_W = $clog2(MAX_LEN + 2);

	localparam int WEIGHT_W = 16;
	localparam int PFX_W = 28;
	localparam int GOOD_W = 11;
	localparam int TOTAL_W = 20;

	localparam logic [GOOD_W-1:0] GOOD_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// One item on its way down the chain of cells.
	typedef struct packed {
		logic valid;
		logic start;
		logic ovf;
		logic wr;
		logic [CNT_W-1:0] rem;
		logic [PFX_W-1:0] value;
		logic [GOOD_W-1:0] good;
	} chain_t;

	// Result fields handed from the tail to the output ports.
	typedef struct packed {
		logic ovf;
		logic [TOTAL_W-1:0] total;
		logic [GOOD_W-1:0] good;
	} result_t;

endpackage

[design/wmic_head.sv]
// Head of the cell chain: keeps the running prefix and the fill count.
// Depends on wmic_pkg.
`timescale 1ns / 1ps

module wmic_head (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic accept,
	input  logic is_target,
	input  logic start_req,
	input  logic [wmic_pkg::WEIGHT_W-1:0] weight,
	output wmic_pkg::chain_t lead
);
	import wmic_pkg::*;

	logic [PFX_W-1:0] prefix_q;
	logic [CNT_W-1:0] count_q;
	chain_t lead_s1;

	logic [PFX_W-1:0] base_prefix;
	logic [PFX_W-1:0] next_prefix;
	logic [CNT_W-1:0] count_eff;
	logic full;
	chain_t lead_d;

	always_comb begin
		base_prefix = start_req ? '0 : prefix_q;
		count_eff = start_req ? CNT_W'(1) : count_q;
		full = count_eff > CNT_W'(MAX_LEN);
		next_prefix = is_target ? base_prefix + PFX_W'(1) : base_prefix - PFX_W'(weight);

		lead_d.valid = accept;
		lead_d.start = start_req;
		lead_d.ovf = full;
		lead_d.wr = !full;
		lead_d.value = next_prefix;
		// The first cell holds entry one; entry zero (always 0) is compared here.
		lead_d.rem = full ? '0 : count_eff - CNT_W'(1);
		lead_d.good = (!full && $signed(next_prefix) > 0) ? GOOD_W'(1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			count_q <= CNT_W'(1);
			lead_s1 <= '0;
		end else if (en) begin
			lead_s1 <= lead_d;
			if (accept && !full) begin
				prefix_q <= next_prefix;
				count_q <= count_eff + CNT_W'(1);
			end else if (accept) begin
				count_q <= count_eff;
			end
		end
	end

	assign lead = lead_s1;

endmodule

[design/wmic_cell.sv]
// One cell of the chain: stores one prefix and compares passing items with it.
// Depends on wmic_pkg.
`timescale 1ns / 1ps

module wmic_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  wmic_pkg::chain_t up,
	output wmic_pkg::chain_t down
);
	import wmic_pkg::*;

	logic [PFX_W-1:0] entry_q;
	chain_t down_q;
	chain_t down_d;

	// While rem is non-zero the entry belongs to an earlier item and is counted;
	// the item with rem at zero and its write flag set stores itself here.
	always_comb begin
		down_d = up;
		if (up.valid && up.rem != '0) begin
			down_d.rem = up.rem - CNT_W'(1);
			if ($signed(entry_q) < $signed(up.value) && up.good != GOOD_MAX)
				down_d.good = up.good + GOOD_W'(1);
		end else if (up.valid && up.wr) begin
			down_d.wr = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up.valid && up.rem == '0 && up.wr)
			entry_q <= up.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q <= '0;
		end else if (en) begin
			down_q <= down_d;
		end
	end

	assign down = down_q;

endmodule

[design/wmic_tail.sv]
// Tail of the chain: keeps the running total and holds the output register.
// Depends on wmic_pkg.
`timescale 1ns / 1ps

module wmic_tail (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  wmic_pkg::chain_t last,
	output logic out_valid,
	output wmic_pkg::result_t res
);
	import wmic_pkg::*;

	logic [TOTAL_W-1:0] total_q;
	logic out_valid_q;
	result_t res_q;

	logic [TOTAL_W-1:0] base_total;
	logic [TOTAL_W:0] sum;
	logic [TOTAL_W-1:0] new_total;

	always_comb begin
		base_total = last.start ? '0 : total_q;
		sum = {1'b0, base_total} + (TOTAL_W + 1)'(last.good);
		new_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= last.valid;
			if (last.valid)
				total_q <= new_total;
		end
	end

	always_ff @(posedge clk) begin
		if (en && last.valid) begin
			res_q.good <= last.good;
			res_q.total <= new_total;
			res_q.ovf <= last.ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

endmodule

[design/weighted_majority_interval_count.sv]
// Weighted majority interval counter, top level.
// Throughput: one item per cycle while the output is not stalled; the whole
// chain advances together, so a stalled output holds every item in flight.
// Reset: asynchronous, active low; clears the prefix, the fill count (to one,
// the empty prefix), the total, the weight (to one) and all valid flags.
`timescale 1ns / 1ps

module weighted_majority_interval_count (
	input  logic clk,
	input  logic arst_n,
	// Configuration: the weight register.
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata,
	// Input items.
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [0] start_req, [7:1] zero
	input  logic s_tuser,         // [0] is_target
	// Result items.
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata,  // [10:0] good_ending_here, [30:11] running_total, [31] zero
	output logic m_tuser          // [0] overflow
);
	import wmic_pkg::*;

	// Each accepted item computes its new prefix in the head and then walks
	// down a row of MAX_LEN cells, one cell per cycle while the output is
	// not stalled. Cell k holds stored prefix k. The item carries a
	// down-counter of the entries it may see: while that counter is non-zero
	// it compares against the cell's entry and bumps its own count; where it
	// reaches zero an item that did not overflow writes its prefix into that
	// cell. Because items follow one another in order, a later item always
	// reaches a cell after an earlier item has written it, and never counts
	// entries written after its own arrival. Entries of an old run left behind
	// by a start request are out of the counter's reach, so the store needs no clearing.

	logic [WEIGHT_W-1:0] weight_q;
	logic en;
	logic accept;
	chain_t link [0:MAX_LEN];
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_W'(1);
		end else if (cfg_we) begin
			weight_q <= cfg_wdata;
		end
	end

	// The chain moves whenever the output register is empty or being taken.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept = s_tvalid && en;

	wmic_head u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.accept    (accept),
		.is_target (s_tuser),
		.start_req (s_tdata[0]),
		.weight    (weight_q),
		.lead      (link[0])
	);

	for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
		wmic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.up     (link[k-1]),
			.down   (link[k])
		);
	end

	wmic_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.last      (link[MAX_LEN]),
		.out_valid (m_tvalid),
		.res       (res)
	);

	assign m_tdata = {1'b0, res.total, res.good};
	assign m_tuser = res.ovf;

endmodule

[design/wmic_checker.sv]
// Port-level checks for the weighted majority interval counter.
// Depends on wmic_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module wmic_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [31:0] m_tdata,
	input logic m_tuser
);
	import wmic_pkg::*;

	// A stalled result must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An ignored item reports no intervals.
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[10:0] == 11'd0)
		else $error("overflow item reports intervals");

	// No more intervals than stored prefixes.
	a_good_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:0] <= 11'(MAX_LEN))
		else $error("interval count above store size");

	// The total includes this item's intervals.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30:11] >= 20'(m_tdata[10:0]))
		else $error("running total below this item's count");

	// The chain only stalls while the output waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

endmodule

bind weighted_majority_interval_count wmic_checker u_wmic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
